### hw/rtl/mcfe_pkg.sv
// Package for the motor command frame encoder: request and result types,
// command codes, register indexes, limit reset values and field widths.
// Depends on nothing; every other file of the block imports it.
package mcfe_pkg;

  // Widths fixed by the frame format.
  localparam int LIMIT_W       = 31;
  localparam int ID_W          = 11;
  localparam int OPERAND_W     = 32;
  localparam int PAYLOAD_W     = 64;
  localparam int POS_FIELD_W   = 16;
  localparam int GAIN_FIELD_W  = 12;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 32;

  // Default code widths of the quantized fields.
  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int FIELD_BITS_DEFAULT    = 12;

  // Command codes.
  localparam logic [1:0] CMD_ENABLE    = 2'd0;
  localparam logic [1:0] CMD_DISABLE   = 2'd1;
  localparam logic [1:0] CMD_POS_SPEED = 2'd2;
  localparam logic [1:0] CMD_MIT       = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_POSITION_LIMIT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY_LIMIT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TORQUE_LIMIT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STIFFNESS_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DAMPING_LIMIT   = 3'd4;

  // Limit reset values, Q16.16.
  localparam logic [LIMIT_W-1:0] POSITION_LIMIT_RESET  = 31'd819200;
  localparam logic [LIMIT_W-1:0] VELOCITY_LIMIT_RESET  = 31'd2949120;
  localparam logic [LIMIT_W-1:0] TORQUE_LIMIT_RESET    = 31'd3276800;
  localparam logic [LIMIT_W-1:0] STIFFNESS_LIMIT_RESET = 31'd32768000;
  localparam logic [LIMIT_W-1:0] DAMPING_LIMIT_RESET   = 31'd327680;

  // Frame constants.
  localparam logic [ID_W-1:0] POS_SPEED_ID_OFFSET = 11'h100;
  localparam logic [7:0]      FILL_BYTE           = 8'hFF;
  localparam logic [7:0]      ENABLE_TAIL         = 8'hFC;
  localparam logic [7:0]      DISABLE_TAIL        = 8'hFD;

  typedef struct packed {
    logic [1:0]                  command;
    logic [ID_W-1:0]             motor_id;
    logic signed [OPERAND_W-1:0] target_position;
    logic signed [OPERAND_W-1:0] target_velocity;
    logic signed [OPERAND_W-1:0] stiffness_gain;
    logic signed [OPERAND_W-1:0] damping_gain;
    logic signed [OPERAND_W-1:0] feedforward_torque;
    logic [OPERAND_W-1:0]        position_float_bits;
    logic [OPERAND_W-1:0]        speed_float_bits;
  } mcfe_request_t;

  typedef struct packed {
    logic [ID_W-1:0]      frame_id;
    logic [PAYLOAD_W-1:0] frame_payload;
  } mcfe_result_t;

  // Effective limits, never zero.
  typedef struct packed {
    logic [LIMIT_W-1:0] position;
    logic [LIMIT_W-1:0] velocity;
    logic [LIMIT_W-1:0] torque;
    logic [LIMIT_W-1:0] stiffness;
    logic [LIMIT_W-1:0] damping;
  } mcfe_limits_t;

endpackage

### hw/rtl/motor_command_frame_encoder_core.sv
// Top level of the motor command frame encoder: request register, five
// quantizer lanes, a side pipeline for identifier and fixed payloads, packing.
// Depends on mcfe_pkg, mcfe_cfg_regs and mcfe_quantizer.

// The encoder turns each request into one CAN frame: an 11-bit standard
// identifier and an 8-byte payload, byte 0 in the top bits. A request is taken
// at a rising edge where start is high and busy is low; busy is high only in
// reset, so a new request may be issued in every cycle. Each result shows on
// result for exactly one cycle with result_valid high, and the receiver cannot
// stall it. Between the accepting edge and the result lie the request register,
// the offset and scale stages, the restoring divider stages that produce one
// code bit per stage, and the output register. Requests come out in the order
// they went in. Enable and disable produce seven 0xFF bytes ending in 0xFC or
// 0xFD; position-speed sends the two float patterns byte-reversed under
// motor_id + 0x100 (wrapping at 11 bits); MIT mode quantizes its five Q16.16
// operands over the limit registers, saturating at code 0 below range and at
// the all-ones code above it. The limit registers are written through the cfg
// channel, which is always ready; write them only while no request is in
// flight. A limit of zero acts as the smallest nonzero limit.
module motor_command_frame_encoder_core #(
  parameter int POSITION_BITS = mcfe_pkg::POSITION_BITS_DEFAULT,
  parameter int FIELD_BITS    = mcfe_pkg::FIELD_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  mcfe_pkg::mcfe_request_t           request,
  output logic                              result_valid,
  output mcfe_pkg::mcfe_result_t            result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mcfe_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mcfe_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mcfe_pkg::*;

  // All lanes run to the depth of the widest code so their results line up.
  localparam int LANE_STAGES = (POSITION_BITS > FIELD_BITS) ? POSITION_BITS : FIELD_BITS;
  // Side pipeline depth: offset stage, scale stage and the lane stages.
  localparam int SIDE_DEPTH  = LANE_STAGES + 2;

  mcfe_limits_t limits;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  mcfe_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  // Request register. The valid bit resets; the payload does not need to.
  mcfe_request_t req;
  logic          req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    req <= request;
  end

  // Quantizer lanes.
  logic [POSITION_BITS-1:0] pos_code;
  logic [FIELD_BITS-1:0]    vel_code;
  logic [FIELD_BITS-1:0]    kp_code;
  logic [FIELD_BITS-1:0]    kd_code;
  logic [FIELD_BITS-1:0]    torque_code;

  mcfe_quantizer #(
    .CODE_BITS (POSITION_BITS),
    .STAGES    (LANE_STAGES),
    .SYMMETRIC (1'b1)
  ) u_pos_lane (
    .clk   (clk),
    .x     (req.target_position),
    .limit (limits.position),
    .code  (pos_code)
  );

  mcfe_quantizer #(
    .CODE_BITS (FIELD_BITS),
    .STAGES    (LANE_STAGES),
    .SYMMETRIC (1'b1)
  ) u_vel_lane (
    .clk   (clk),
    .x     (req.target_velocity),
    .limit (limits.velocity),
    .code  (vel_code)
  );

  mcfe_quantizer #(
    .CODE_BITS (FIELD_BITS),
    .STAGES    (LANE_STAGES),
    .SYMMETRIC (1'b0)
  ) u_kp_lane (
    .clk   (clk),
    .x     (req.stiffness_gain),
    .limit (limits.stiffness),
    .code  (kp_code)
  );

  mcfe_quantizer #(
    .CODE_BITS (FIELD_BITS),
    .STAGES    (LANE_STAGES),
    .SYMMETRIC (1'b0)
  ) u_kd_lane (
    .clk   (clk),
    .x     (req.damping_gain),
    .limit (limits.damping),
    .code  (kd_code)
  );

  mcfe_quantizer #(
    .CODE_BITS (FIELD_BITS),
    .STAGES    (LANE_STAGES),
    .SYMMETRIC (1'b1)
  ) u_torque_lane (
    .clk   (clk),
    .x     (req.feedforward_torque),
    .limit (limits.torque),
    .code  (torque_code)
  );

  // The identifier and the fixed payloads need no arithmetic worth a stage, so
  // they are formed from the request register and then just travel alongside
  // the lanes with the valid bit.
  logic [ID_W-1:0]      side_id_next;
  logic [PAYLOAD_W-1:0] side_payload_next;

  always_comb begin
    side_id_next      = req.motor_id;
    side_payload_next = '0;
    unique case (req.command)
      CMD_ENABLE: begin
        side_payload_next = {{7{FILL_BYTE}}, ENABLE_TAIL};
      end
      CMD_DISABLE: begin
        side_payload_next = {{7{FILL_BYTE}}, DISABLE_TAIL};
      end
      CMD_POS_SPEED: begin
        side_id_next      = req.motor_id + POS_SPEED_ID_OFFSET;
        side_payload_next = {req.position_float_bits[7:0],   req.position_float_bits[15:8],
                             req.position_float_bits[23:16], req.position_float_bits[31:24],
                             req.speed_float_bits[7:0],      req.speed_float_bits[15:8],
                             req.speed_float_bits[23:16],    req.speed_float_bits[31:24]};
      end
      default: ;
    endcase
  end

  logic                 side_valid   [0:SIDE_DEPTH-1];
  logic                 side_mit     [0:SIDE_DEPTH-1];
  logic [ID_W-1:0]      side_id      [0:SIDE_DEPTH-1];
  logic [PAYLOAD_W-1:0] side_payload [0:SIDE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      side_valid[0] <= 1'b0;
    end else begin
      side_valid[0] <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    side_mit[0]     <= (req.command == CMD_MIT);
    side_id[0]      <= side_id_next;
    side_payload[0] <= side_payload_next;
  end

  for (genvar k = 1; k < SIDE_DEPTH; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side_valid[k] <= 1'b0;
      end else begin
        side_valid[k] <= side_valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      side_mit[k]     <= side_mit[k-1];
      side_id[k]      <= side_id[k-1];
      side_payload[k] <= side_payload[k-1];
    end
  end

  // MIT payload: position in the top 16 bits, then velocity, kp, kd and
  // torque in 12-bit fields, each code zero-extended into its field.
  logic [PAYLOAD_W-1:0] mit_payload;

  assign mit_payload = {POS_FIELD_W'(pos_code),
                        GAIN_FIELD_W'(vel_code),
                        GAIN_FIELD_W'(kp_code),
                        GAIN_FIELD_W'(kd_code),
                        GAIN_FIELD_W'(torque_code)};

  // Output register: the strobe lasts one cycle per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= side_valid[SIDE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    result.frame_id      <= side_id[SIDE_DEPTH-1];
    result.frame_payload <= side_mit[SIDE_DEPTH-1] ? mit_payload
                                                   : side_payload[SIDE_DEPTH-1];
  end

endmodule

### hw/rtl/mcfe_cfg_regs.sv
// Limit register file of the motor command frame encoder.
// Depends on mcfe_pkg for register indexes, reset values and the limits struct.
module mcfe_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [mcfe_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mcfe_pkg::CFG_DATA_W-1:0]   cfg_data,
  output mcfe_pkg::mcfe_limits_t            limits
);
  import mcfe_pkg::*;

  logic [LIMIT_W-1:0] position_limit;
  logic [LIMIT_W-1:0] velocity_limit;
  logic [LIMIT_W-1:0] torque_limit;
  logic [LIMIT_W-1:0] stiffness_limit;
  logic [LIMIT_W-1:0] damping_limit;
  logic [LIMIT_W-1:0] wdata;

  assign wdata = cfg_data[LIMIT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      position_limit  <= POSITION_LIMIT_RESET;
      velocity_limit  <= VELOCITY_LIMIT_RESET;
      torque_limit    <= TORQUE_LIMIT_RESET;
      stiffness_limit <= STIFFNESS_LIMIT_RESET;
      damping_limit   <= DAMPING_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POSITION_LIMIT:  position_limit  <= wdata;
        REG_VELOCITY_LIMIT:  velocity_limit  <= wdata;
        REG_TORQUE_LIMIT:    torque_limit    <= wdata;
        REG_STIFFNESS_LIMIT: stiffness_limit <= wdata;
        REG_DAMPING_LIMIT:   damping_limit   <= wdata;
        default: ;
      endcase
    end
  end

  // A limit of zero behaves as the smallest nonzero limit.
  function automatic logic [LIMIT_W-1:0] nonzero(input logic [LIMIT_W-1:0] v);
    return (v == '0) ? LIMIT_W'(1) : v;
  endfunction

  always_comb begin
    limits.position  = nonzero(position_limit);
    limits.velocity  = nonzero(velocity_limit);
    limits.torque    = nonzero(torque_limit);
    limits.stiffness = nonzero(stiffness_limit);
    limits.damping   = nonzero(damping_limit);
  end

endmodule

### hw/rtl/mcfe_quantizer.sv
// One quantizer lane: offset and range check, scaling by 2^bits - 1, then a
// pipelined restoring divider giving one code bit per stage.
// Depends on mcfe_pkg for operand and limit widths.
module mcfe_quantizer #(
  parameter int CODE_BITS = mcfe_pkg::FIELD_BITS_DEFAULT,
  parameter int STAGES    = mcfe_pkg::FIELD_BITS_DEFAULT,
  parameter bit SYMMETRIC = 1'b1
) (
  input  logic                                clk,
  input  logic signed [mcfe_pkg::OPERAND_W-1:0] x,
  input  logic [mcfe_pkg::LIMIT_W-1:0]        limit,
  output logic [CODE_BITS-1:0]                code
);
  import mcfe_pkg::*;

  localparam int DW  = OPERAND_W;          // remainder and span width
  localparam int NW  = OPERAND_W + 2;      // signed offset value width
  localparam int DVW = DW + CODE_BITS;     // scaled dividend width

  logic [DW-1:0] span;
  logic [NW-1:0] num;

  // Range of the lane: -L..+L spans 2L, 0..L spans L.
  assign span = SYMMETRIC ? {limit, 1'b0} : {1'b0, limit};

  always_comb begin
    if (SYMMETRIC) begin
      num = {{2{x[OPERAND_W-1]}}, x} + NW'(limit);
    end else begin
      num = {{2{x[OPERAND_W-1]}}, x};
    end
  end

  // Offset stage: clamp flags and the in-range offset.
  logic [DW-1:0] off_a;
  logic          zero_a;
  logic          sat_a;

  always_ff @(posedge clk) begin
    off_a  <= num[DW-1:0];
    zero_a <= num[NW-1] || (num == '0);
    sat_a  <= !num[NW-1] && (num[DW:0] >= {1'b0, span});
  end

  // Scale stage: offset * (2^CODE_BITS - 1) as a shift and subtract.
  logic [DVW-1:0] dvd;
  assign dvd = {off_a, {CODE_BITS{1'b0}}} - DVW'(off_a);

  logic [DW-1:0]        rem  [0:STAGES];
  logic [CODE_BITS-1:0] low  [0:STAGES];
  logic [CODE_BITS-1:0] quot [0:STAGES];
  logic                 zero [0:STAGES];
  logic                 sat  [0:STAGES];

  always_ff @(posedge clk) begin
    rem[0]  <= dvd[DVW-1:CODE_BITS];
    low[0]  <= dvd[CODE_BITS-1:0];
    quot[0] <= '0;
    zero[0] <= zero_a;
    sat[0]  <= sat_a;
  end

  // The dividend stays below span * 2^CODE_BITS, so CODE_BITS steps finish it;
  // the remaining stages only delay the result to the common depth.
  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    if (j < CODE_BITS) begin : g_div
      logic [DW:0] trial;
      logic [DW:0] diff;
      assign trial = {rem[j], low[j][CODE_BITS-1]};
      assign diff  = trial - {1'b0, span};
      always_ff @(posedge clk) begin
        if (!diff[DW]) begin
          rem[j+1]  <= diff[DW-1:0];
          quot[j+1] <= {quot[j][CODE_BITS-2:0], 1'b1};
        end else begin
          rem[j+1]  <= trial[DW-1:0];
          quot[j+1] <= {quot[j][CODE_BITS-2:0], 1'b0};
        end
        low[j+1]  <= {low[j][CODE_BITS-2:0], 1'b0};
        zero[j+1] <= zero[j];
        sat[j+1]  <= sat[j];
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        rem[j+1]  <= rem[j];
        low[j+1]  <= low[j];
        quot[j+1] <= quot[j];
        zero[j+1] <= zero[j];
        sat[j+1]  <= sat[j];
      end
    end
  end

  always_comb begin
    if (zero[STAGES]) begin
      code = '0;
    end else if (sat[STAGES]) begin
      code = '1;
    end else begin
      code = quot[STAGES];
    end
  end

endmodule
